// ===== rtl/core/pcsp_pkg.sv =====
// Shared types and constants for the PNG chunk stream parser.
// Holds the phase, byte role and chunk class codes, the chunk tag table and the result record.
// No dependencies.
package pcsp_pkg;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_BODY = 3'd3,
    PH_CRC  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_SIG     = 3'd0,
    ROLE_LEN     = 3'd1,
    ROLE_TYPE    = 3'd2,
    ROLE_PAYLOAD = 3'd3,
    ROLE_HDR     = 3'd4,
    ROLE_CRC     = 3'd5,
    ROLE_DONE    = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    CL_NONE    = 3'd0,
    CL_IHDR    = 3'd1,
    CL_PLTE    = 3'd2,
    CL_IDAT    = 3'd3,
    CL_ICCP    = 3'd4,
    CL_KNOWN   = 3'd5,
    CL_UNKNOWN = 3'd6,
    CL_IEND    = 3'd7
  } class_t;

  localparam int unsigned SIG_BYTES   = 8;
  localparam int unsigned FIELD_BYTES = 4;
  localparam int unsigned HDR_W_END   = 4;   // width bytes 0..3
  localparam int unsigned HDR_H_END   = 8;   // height bytes 4..7
  localparam int unsigned HDR_WD_END  = 12;  // packed word bytes 8..11
  localparam int unsigned IHDR_BODY   = 13;
  localparam int unsigned N_KNOWN     = 19;

  localparam logic [31:0] TAG_IEND = "IEND";
  localparam logic [31:0] TAG_IHDR = "IHDR";
  localparam logic [31:0] TAG_PLTE = "PLTE";
  localparam logic [31:0] TAG_IDAT = "IDAT";
  localparam logic [31:0] TAG_ICCP = "iCCP";

  localparam logic [31:0] KNOWN_TAGS [N_KNOWN] = '{
    "bKGD", "cHRM", "dSIG", "eXIf", "gAMA", "hIST", "iTXt", "pHYs",
    "sBIT", "sPLT", "sRGB", "sTER", "tEXt", "tIME", "tRNS", "zTXt",
    "sCAL", "pCAL", "oFFs"
  };

  typedef struct packed {
    role_t       role;
    class_t      cls;
    logic [7:0]  payload;
    logic        last;
    logic [31:0] ctype;
    logic [31:0] clen;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] word;
    logic [7:0]  hbyte;
    logic        hvalid;
  } res_t;

endpackage

// ===== rtl/core/pcsp_classify.sv =====
// Chunk type classifier: maps a four-character tag to a chunk class.
// Depends on pcsp_pkg for the tag table and class codes.
module pcsp_classify
  import pcsp_pkg::*;
(
  input  logic [31:0] tag,
  output class_t      cls
);

  logic known_hit;

  always_comb begin
    known_hit = 1'b0;
    for (int k = 0; k < N_KNOWN; k++) begin
      if (tag == KNOWN_TAGS[5'(k)]) begin
        known_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (tag == TAG_IEND) begin
      cls = CL_IEND;
    end else if (tag == TAG_IHDR) begin
      cls = CL_IHDR;
    end else if (tag == TAG_PLTE) begin
      cls = CL_PLTE;
    end else if (tag == TAG_IDAT) begin
      cls = CL_IDAT;
    end else if (tag == TAG_ICCP) begin
      cls = CL_ICCP;
    end else if (known_hit) begin
      cls = CL_KNOWN;
    end else begin
      cls = CL_UNKNOWN;
    end
  end

endmodule

// ===== rtl/core/pcsp_parse_core.sv =====
// Parser state and per-byte step logic for the PNG chunk stream parser.
// Depends on pcsp_pkg and pcsp_classify.
module pcsp_parse_core
  import pcsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  input  logic       start_of_file,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  class_t      cls_r, cls_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] word_r, word_nxt;

  // Effective state: a start mark behaves as a reset just before the step
  phase_t      e_phase;
  logic [31:0] e_cnt, e_len, e_type, e_width, e_height, e_word;
  class_t      e_cls;
  logic [31:0] cnt_inc;
  logic [31:0] type_shift;
  class_t      tag_cls;
  role_t       role;
  logic [7:0]  pay;
  logic        last;
  logic        hv;
  logic [7:0]  hb;

  assign e_phase  = start_of_file ? PH_SIG  : phase_r;
  assign e_cnt    = start_of_file ? '0      : cnt_r;
  assign e_len    = start_of_file ? '0      : len_r;
  assign e_type   = start_of_file ? '0      : type_r;
  assign e_cls    = start_of_file ? CL_NONE : cls_r;
  assign e_width  = start_of_file ? '0      : width_r;
  assign e_height = start_of_file ? '0      : height_r;
  assign e_word   = start_of_file ? '0      : word_r;

  assign cnt_inc    = e_cnt + 32'd1;
  assign type_shift = {e_type[23:0], data_byte};

  pcsp_classify u_classify (
    .tag (type_shift),
    .cls (tag_cls)
  );

  always_comb begin
    phase_nxt  = e_phase;
    cnt_nxt    = e_cnt;
    len_nxt    = e_len;
    type_nxt   = e_type;
    cls_nxt    = e_cls;
    width_nxt  = e_width;
    height_nxt = e_height;
    word_nxt   = e_word;
    role       = ROLE_DONE;
    pay        = 8'd0;
    last       = 1'b0;
    hv         = 1'b0;
    hb         = 8'd0;
    case (e_phase)
      PH_SIG: begin
        role    = ROLE_SIG;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 32'(SIG_BYTES)) begin
          phase_nxt = PH_LEN;
          cnt_nxt   = '0;
        end
      end
      PH_LEN: begin
        role    = ROLE_LEN;
        cnt_nxt = cnt_inc;
        if (e_cnt == '0) begin
          // first length byte: drop the previous chunk's tag and length
          len_nxt  = {24'd0, data_byte};
          type_nxt = '0;
          cls_nxt  = CL_NONE;
        end else begin
          len_nxt = {e_len[23:0], data_byte};
        end
        if (cnt_inc >= 32'(FIELD_BYTES)) begin
          phase_nxt = PH_TYPE;
          cnt_nxt   = '0;
        end
      end
      PH_TYPE: begin
        role     = ROLE_TYPE;
        type_nxt = type_shift;
        cnt_nxt  = cnt_inc;
        if (cnt_inc >= 32'(FIELD_BYTES)) begin
          cnt_nxt = '0;
          cls_nxt = tag_cls;
          if (tag_cls == CL_IEND) begin
            phase_nxt = PH_DONE;
          end else if (tag_cls == CL_IHDR || e_len != '0) begin
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt = PH_CRC;
          end
        end
      end
      PH_BODY: begin
        cnt_nxt = cnt_inc;
        if (e_cls == CL_IHDR) begin
          role = ROLE_HDR;
          if (e_cnt < 32'(HDR_W_END)) begin
            width_nxt = {e_width[23:0], data_byte};
          end else if (e_cnt < 32'(HDR_H_END)) begin
            height_nxt = {e_height[23:0], data_byte};
          end else if (e_cnt < 32'(HDR_WD_END)) begin
            word_nxt = {e_word[23:0], data_byte};
          end else begin
            hv = 1'b1;
            hb = data_byte;
          end
          if (cnt_inc >= 32'(IHDR_BODY)) begin
            phase_nxt = PH_CRC;
            cnt_nxt   = '0;
          end
        end else begin
          role = ROLE_PAYLOAD;
          pay  = data_byte;
          if (cnt_inc >= e_len) begin
            last      = 1'b1;
            phase_nxt = PH_CRC;
            cnt_nxt   = '0;
          end
        end
      end
      PH_CRC: begin
        role    = ROLE_CRC;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 32'(FIELD_BYTES)) begin
          phase_nxt = PH_LEN;
          cnt_nxt   = '0;
        end
      end
      default: begin
        role = ROLE_DONE;
      end
    endcase
  end

  always_comb begin
    res.role   = role;
    res.cls    = cls_nxt;
    res.payload = pay;
    res.last   = last;
    res.ctype  = type_nxt;
    res.clen   = len_nxt;
    res.width  = hv ? e_width : '0;
    res.height = hv ? e_height : '0;
    res.word   = hv ? e_word : '0;
    res.hbyte  = hb;
    res.hvalid = hv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      cnt_r    <= '0;
      len_r    <= '0;
      type_r   <= '0;
      cls_r    <= CL_NONE;
      width_r  <= '0;
      height_r <= '0;
      word_r   <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      cls_r    <= cls_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      word_r   <= word_nxt;
    end
  end

endmodule

// ===== rtl/core/png_chunk_stream_parser.sv =====
// PNG chunk stream parser top level: input register, parse core and result register.
// Depends on pcsp_pkg and pcsp_parse_core.
//
// Feed a PNG file one byte per transfer; every accepted byte produces exactly
// one result transfer that says what the byte is (signature, length, type,
// payload, header field, CRC, or ignored after IEND), with the current
// chunk's class, tag and declared length. Non-IHDR payload bytes pass through
// with tlast on the final one; IHDR always consumes 13 body bytes and reports
// width, height, the packed depth/color/compression/filter word and the
// interlace byte on the thirteenth. CRCs are skipped, not checked. Set the
// start flag in in_tuser to restart parsing at a new signature. The block
// takes one byte every cycle while the output is not stalled: each byte is
// held in an input register, the phase and counter update is combinational
// logic in the parse core, and the result register loads the parsed result
// when its slot is free or being emptied. Back-pressure on the output holds
// both stages; the input stays ready while either stage can move.
module png_chunk_stream_parser
  import pcsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] start_of_file
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] payload_byte, [39:8] chunk_type, [71:40] chunk_length,
  // [103:72] image_width, [135:104] image_height, [167:136] header_word,
  // [175:168] header_byte
  output logic [175:0] out_tdata,
  output logic         out_tlast,  // payload_last
  // [2:0] byte_role, [5:3] chunk_class, [6] header_valid
  output logic [6:0]   out_tuser
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_sof_r;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       step_res;
  logic       advance;

  // advance the held byte into the result register when that slot is free or being taken
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  pcsp_parse_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (advance),
    .data_byte     (s1_byte_r),
    .start_of_file (s1_sof_r),
    .res           (step_res)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // input register payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_sof_r  <= in_tuser;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {out_res_r.hbyte, out_res_r.word, out_res_r.height,
                       out_res_r.width, out_res_r.clen, out_res_r.ctype,
                       out_res_r.payload};
  assign out_tuser  = {out_res_r.hvalid, out_res_r.cls, out_res_r.role};

  // the input stalls only when both stages are full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with a free stage");

  // a last mark only rides on a payload byte
  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.last) |-> (out_res_r.role == ROLE_PAYLOAD))
    else $error("last mark on a non-payload byte");

  // header values are reported only inside an IHDR body
  a_hdr_in_ihdr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.hvalid) |->
      (out_res_r.role == ROLE_HDR && out_res_r.cls == CL_IHDR))
    else $error("header valid outside IHDR body");

  // ignored bytes only follow an IEND tag
  a_done_after_iend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.role == ROLE_DONE) |-> (out_res_r.cls == CL_IEND))
    else $error("trailing byte without IEND");

  // a transfer held on the output keeps its contents
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_res_r))
    else $error("stalled result changed");

endmodule
